>>> design/mse_pkg.sv
`timescale 1ns / 1ps

package mse_pkg;

    localparam int DEPTH  = 64;
    localparam int KEY_W  = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PRIME,
        ST_MERGE,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic sort_start;
        logic run_prime;
        logic merge_step;
        logic emit_start;
        logic emit_next;
        logic batch_clear;
    } t_cmd;

    typedef struct packed {
        logic pass_more;
        logic run_end;
        logic emit_last;
    } t_status;

endpackage

>>> design/mse_ctrl.sv
`timescale 1ns / 1ps

module mse_ctrl
    import mse_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_last_in,
    input  logic    i_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall,
    output logic    o_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && i_last_in) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = i_status.pass_more ? ST_PRIME : ST_EMIT_RD;
            end
            ST_PRIME: begin
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (i_status.run_end) begin
                    n_state = ST_CHECK;
                end
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (!i_stall) begin
                    n_state = i_status.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall          = 1'b0;
                o_cmd.load       = i_valid;
                o_cmd.sort_start = i_valid && i_last_in;
            end
            ST_CHECK: begin
                o_cmd.emit_start = !i_status.pass_more;
            end
            ST_PRIME: begin
                o_cmd.run_prime = 1'b1;
            end
            ST_MERGE: begin
                o_cmd.merge_step = 1'b1;
            end
            ST_EMIT_RD: begin
                o_cmd = '0;
            end
            ST_EMIT_OUT: begin
                o_valid           = 1'b1;
                o_cmd.emit_next   = !i_stall && !i_status.emit_last;
                o_cmd.batch_clear = !i_stall && i_status.emit_last;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> design/mse_dp.sv
`timescale 1ns / 1ps

module mse_dp
    import mse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [KEY_W-1:0]  i_value_in,
    output t_status           o_status,
    output logic [KEY_W-1:0]  o_value_out,
    output logic              o_last_out,
    output logic              o_overflow
);

    // two stores: bank 0 is the key store, bank 1 the scratch store
    logic [KEY_W-1:0] r_mem0 [DEPTH];
    logic [KEY_W-1:0] r_mem1 [DEPTH];
    logic [KEY_W-1:0] r_q0a, r_q0b, r_q1a, r_q1b;

    logic [CNT_W-1:0]  r_fill;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_width;
    logic [CNT_W-1:0]  r_lo;
    logic [CNT_W-1:0]  r_mid;
    logic [CNT_W-1:0]  r_hi;
    logic [CNT_W-1:0]  r_a;
    logic [CNT_W-1:0]  r_b;
    logic [CNT_W-1:0]  r_k;
    logic              r_sel;
    logic [ADDR_W-1:0] r_idx;

    logic [SUM_W-1:0]  mid_sum, hi_sum, lo_next;
    logic [CNT_W-1:0]  mid_c, hi_c;
    logic [CNT_W-1:0]  n_a, n_b, k_inc;
    logic [KEY_W-1:0]  src_a, src_b, merge_val;
    logic              a_live, b_live, take_b, fill_room;
    logic [ADDR_W-1:0] rd_a, rd_b;
    logic              we0, we1;
    logic [ADDR_W-1:0] wa0;
    logic [KEY_W-1:0]  wd0;

    assign mid_sum = SUM_W'(r_lo) + SUM_W'(r_width);
    assign hi_sum  = SUM_W'(r_lo) + (SUM_W'(r_width) << 1);
    assign lo_next = hi_sum;
    assign mid_c   = (mid_sum > SUM_W'(r_fill)) ? r_fill : mid_sum[CNT_W-1:0];
    assign hi_c    = (hi_sum > SUM_W'(r_fill)) ? r_fill : hi_sum[CNT_W-1:0];

    assign src_a = r_sel ? r_q1a : r_q0a;
    assign src_b = r_sel ? r_q1b : r_q0b;

    // take the right head only when it is strictly smaller: keeps the sort stable
    assign a_live    = r_a < r_mid;
    assign b_live    = r_b < r_hi;
    assign take_b    = b_live && (!a_live || ($signed(src_a) > $signed(src_b)));
    assign merge_val = take_b ? src_b : src_a;
    assign n_a       = take_b ? r_a : r_a + CNT_W'(1);
    assign n_b       = take_b ? r_b + CNT_W'(1) : r_b;
    assign k_inc     = r_k + CNT_W'(1);
    assign fill_room = r_fill < CNT_W'(DEPTH);

    always_comb begin
        rd_a = r_idx;
        rd_b = r_b[ADDR_W-1:0];
        if (i_cmd.run_prime) begin
            rd_a = r_lo[ADDR_W-1:0];
            rd_b = mid_c[ADDR_W-1:0];
        end else if (i_cmd.merge_step) begin
            rd_a = n_a[ADDR_W-1:0];
            rd_b = n_b[ADDR_W-1:0];
        end
    end

    assign we0 = (i_cmd.load && fill_room) || (i_cmd.merge_step && r_sel);
    assign wa0 = i_cmd.load ? r_fill[ADDR_W-1:0] : r_k[ADDR_W-1:0];
    assign wd0 = i_cmd.load ? i_value_in : merge_val;
    assign we1 = i_cmd.merge_step && !r_sel;

    always_ff @(posedge i_clk) begin
        if (we0) begin
            r_mem0[wa0] <= wd0;
        end
        r_q0a <= r_mem0[rd_a];
        r_q0b <= r_mem0[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_mem1[r_k[ADDR_W-1:0]] <= merge_val;
        end
        r_q1a <= r_mem1[rd_a];
        r_q1b <= r_mem1[rd_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_ovf   <= 1'b0;
            r_width <= CNT_W'(1);
            r_lo    <= '0;
            r_sel   <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.load) begin
                if (fill_room) begin
                    r_fill <= r_fill + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.sort_start) begin
                r_width <= CNT_W'(1);
                r_lo    <= '0;
                r_sel   <= 1'b0;
            end
            if (i_cmd.merge_step && (k_inc == r_hi)) begin
                // advance to the next run pair, or to the next pass in the other bank
                if (lo_next >= SUM_W'(r_fill)) begin
                    r_lo    <= '0;
                    r_width <= r_width << 1;
                    r_sel   <= !r_sel;
                end else begin
                    r_lo <= lo_next[CNT_W-1:0];
                end
            end
            if (i_cmd.emit_start) begin
                r_idx <= '0;
            end else if (i_cmd.emit_next) begin
                r_idx <= r_idx + ADDR_W'(1);
            end
            if (i_cmd.batch_clear) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_prime) begin
            r_a   <= r_lo;
            r_b   <= mid_c;
            r_k   <= r_lo;
            r_mid <= mid_c;
            r_hi  <= hi_c;
        end else if (i_cmd.merge_step) begin
            r_a <= n_a;
            r_b <= n_b;
            r_k <= k_inc;
        end
    end

    assign o_status.pass_more = r_width < r_fill;
    assign o_status.run_end   = k_inc == r_hi;
    assign o_status.emit_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_fill;

    assign o_value_out = src_a;
    assign o_last_out  = o_status.emit_last;
    assign o_overflow  = r_ovf;

endmodule

>>> design/merge_sort_engine_core.sv
`timescale 1ns / 1ps

// Batch sorter for signed 32-bit keys.
// Input channel (i_valid / o_stall): one key per transfer, i_last_in closes the
// batch. Keys load at one per cycle; o_stall stays low while the block loads.
// Up to DEPTH keys are kept; further keys are dropped and every result of that
// batch carries o_overflow. A dropped closing key still closes the batch.
// After the closing transfer o_stall rises and the key store is sorted by
// bottom-up merge passes that alternate between the key store and a scratch
// store. One merged element is written per cycle, limited by the single write
// port per bank; each run pair also takes a pass check and a read-priming step.
// Output channel (o_valid / i_stall): the n sorted keys, ascending, in n
// transfers, each a store read, then a present step; o_last_out marks the
// greatest. While i_stall is high the result holds. After the final
// transfer the block returns to loading.
// Reset (i_rst_n low, synchronous) empties the batch and returns to loading.

module merge_sort_engine_core
    import mse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [KEY_W-1:0] i_value_in,
    input  logic             i_last_in,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [KEY_W-1:0] o_value_out,
    output logic             o_last_out,
    output logic             o_overflow
);

    t_cmd    cmd;
    t_status status;

    // sequencer: load, merge passes, emission
    mse_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_last_in (i_last_in),
        .i_stall   (i_stall),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_stall   (o_stall),
        .o_valid   (o_valid)
    );

    // stores, merge pointers and pass counters
    mse_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value_in  (i_value_in),
        .o_status    (status),
        .o_value_out (o_value_out),
        .o_last_out  (o_last_out),
        .o_overflow  (o_overflow)
    );

endmodule

>>> design/mse_checker.sv
`timescale 1ns / 1ps

module mse_checker
    import mse_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             i_last_in,
    input logic             o_valid,
    input logic             i_stall,
    input logic [KEY_W-1:0] o_value_out,
    input logic             o_last_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value_out) && $stable(o_last_out)))
        else $error("stalled result changed");

    // no input is taken while results are being delivered
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open during emission");

    // a closing transfer starts the sort and closes the input side
    a_close_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_last_in) |=> (o_stall && !o_valid))
        else $error("input not closed after batch end");

    // after the final result the block goes back to loading
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_out) |=> (!o_valid && !o_stall))
        else $error("block did not return to loading");

endmodule

bind merge_sort_engine_core mse_checker u_mse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_last_in   (i_last_in),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_value_out (o_value_out),
    .o_last_out  (o_last_out)
);

>>> bench/sort_check_pkg.sv
`timescale 1ns / 1ps

package sort_check_pkg;

    import mse_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
        logic             overflow;
    } t_sorted_key;

    class sort_scoreboard;

        logic [KEY_W-1:0] batch_keys[$];
        logic             batch_dropped;
        t_sorted_key      sorted_pending[$];
        int               mismatch_count;

        function new();
            batch_dropped  = 1'b0;
            mismatch_count = 0;
        endfunction

        function void report(string msg);
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("MISMATCH %0d: %s", mismatch_count, msg);
            end
        endfunction

        // Hold keys until the closing transfer, then queue them in stable ascending order.
        function void note_key(logic [KEY_W-1:0] key, logic last);
            logic [KEY_W-1:0] held;
            int               j;
            t_sorted_key      entry;
            if (batch_keys.size() < DEPTH) begin
                batch_keys.push_back(key);
            end else begin
                batch_dropped = 1'b1;
            end
            if (last) begin
                // insertion sort: shift only strictly greater keys, so equal keys keep order
                for (int i = 1; i < batch_keys.size(); i++) begin
                    held = batch_keys[i];
                    j    = i - 1;
                    while (j >= 0 && $signed(batch_keys[j]) > $signed(held)) begin
                        batch_keys[j + 1] = batch_keys[j];
                        j--;
                    end
                    batch_keys[j + 1] = held;
                end
                foreach (batch_keys[i]) begin
                    entry.key      = batch_keys[i];
                    entry.last     = (i == batch_keys.size() - 1);
                    entry.overflow = batch_dropped;
                    sorted_pending.push_back(entry);
                end
                batch_keys.delete();
                batch_dropped = 1'b0;
            end
        endfunction

        function void check_result(logic [KEY_W-1:0] key, logic last, logic overflow);
            t_sorted_key want;
            if (sorted_pending.size() == 0) begin
                report($sformatf("unexpected result key=%0d last=%0b overflow=%0b",
                                 $signed(key), last, overflow));
            end else begin
                want = sorted_pending.pop_front();
                if (want.key !== key || want.last !== last || want.overflow !== overflow) begin
                    report($sformatf("expected key=%0d last=%0b overflow=%0b, got key=%0d last=%0b overflow=%0b",
                                     $signed(want.key), want.last, want.overflow,
                                     $signed(key), last, overflow));
                end
            end
        endfunction

    endclass

endpackage

>>> bench/testbench.sv
`timescale 1ns / 1ps

// Drive keys into the sorter in batches, predict each batch's sorted output in
// the scoreboard, and check every output transfer against it.

module testbench;

    import mse_pkg::*;
    import sort_check_pkg::*;

    localparam int TARGET_KEYS  = 380;
    localparam int DRAIN_CYCLES = 200;
    localparam int LIMIT_CYCLES = 400000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [KEY_W-1:0] i_value_in;
    logic             i_last_in;
    logic             o_valid;
    logic             i_stall = 1'b0;
    logic [KEY_W-1:0] o_value_out;
    logic             o_last_out;
    logic             o_overflow;

    sort_scoreboard   sb;
    logic [KEY_W-1:0] batch_q[$];
    int               keys_sent;
    int               burst_left;
    int               gap_cap;
    int               batch_len;
    int               batch_idx;
    int               stall_mode  = 0;
    int               stall_timer = 0;
    int               stall_phase = 0;

    merge_sort_engine_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_value_in  (i_value_in),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_value_out (o_value_out),
        .o_last_out  (o_last_out),
        .o_overflow  (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Pick a key: mostly full-range random, with extremes and a narrow band
    // mixed in so that duplicate keys show up often.
    function automatic logic [KEY_W-1:0] random_key();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return $urandom;
        end else if (pick < 70) begin
            case ($urandom_range(0, 3))
                0:       return {1'b0, {(KEY_W-1){1'b1}}};
                1:       return {1'b1, {(KEY_W-1){1'b0}}};
                2:       return '0;
                default: return '1;
            endcase
        end else begin
            return KEY_W'($signed($urandom_range(0, 8)) - 4);
        end
    endfunction

    // Move one key across the input channel. The sender works in bursts:
    // once a burst runs out, drop valid for a random gap, then start another.
    task automatic send_key(input logic [KEY_W-1:0] key, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_cap);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_value_in <= key;
        i_last_in  <= last;
        // hold the payload until a transfer happens
        do @(posedge i_clk); while (o_stall);
        sb.note_key(key, last);
        keys_sent++;
    endtask

    // Send the keys in batch_q, closing the batch on the final one.
    task automatic send_batch();
        for (int i = 0; i < batch_q.size(); i++) begin
            send_key(batch_q[i], i == batch_q.size() - 1);
        end
        batch_q.delete();
    endtask

    // Receiver: check each output transfer, then pick the next stall value.
    // The stall pattern switches between never, light, heavy and periodic.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result(o_value_out, o_last_out, o_overflow);
        end
        if (stall_timer == 0) begin
            stall_mode  = $urandom_range(0, 3);
            stall_timer = $urandom_range(50, 300);
        end
        stall_timer--;
        stall_phase = (stall_phase + 1) % 7;
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            2:       i_stall <= ($urandom_range(0, 9) < 6);
            default: i_stall <= (stall_phase < 3);
        endcase
    end

    // Watchdog: end the run if it hangs.
    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("merge_sort_engine_core verification failed");
        $finish;
    end

    initial begin
        sb          = new();
        keys_sent   = 0;
        burst_left  = 0;
        gap_cap     = 4;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_value_in <= '0;
        i_last_in  <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed batches: a single key, the two extremes, the extremes with zero and
        // minus one, a reversed run, repeated keys (stability) and alternating bit patterns.
        batch_q = '{{1'b0, {(KEY_W-1){1'b1}}}};
        send_batch();
        batch_q = '{{1'b0, {(KEY_W-1){1'b1}}}, {1'b1, {(KEY_W-1){1'b0}}}};
        send_batch();
        batch_q = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
        send_batch();
        batch_q = '{32'd5, 32'd4, 32'd3, 32'd2, 32'd1};
        send_batch();
        batch_q = '{32'd3, 32'hffff_fffd, 32'd3, 32'hffff_fffd, 32'd3, 32'd0};
        send_batch();
        batch_q = '{32'h5555_5555, 32'haaaa_aaaa, 32'h0000_0001, 32'h8000_0001};
        send_batch();

        // Random batches. Force one full batch and one that overruns the store
        // (its closing key is dropped) early on; most batches stay small.
        batch_idx = 0;
        while (keys_sent < TARGET_KEYS) begin
            if (batch_idx == 0) begin
                batch_len = DEPTH;
            end else if (batch_idx == 1) begin
                batch_len = DEPTH + 3;
            end else begin
                case ($urandom_range(0, 19))
                    0:       batch_len = DEPTH;
                    1:       batch_len = $urandom_range(DEPTH + 1, DEPTH + 6);
                    2, 3, 4: batch_len = $urandom_range(11, 40);
                    default: batch_len = $urandom_range(1, 10);
                endcase
            end
            // alternate between gap-free stretches and gappy ones
            gap_cap = ($urandom_range(0, 2) == 0) ? 0 : 6;
            for (int i = 0; i < batch_len; i++) begin
                batch_q.push_back(random_key());
            end
            send_batch();
            batch_idx++;
        end
        i_valid   <= 1'b0;
        i_last_in <= 1'b0;

        // Wait for the last results, then keep watching to catch strays.
        while (sb.sorted_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.sorted_pending.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.sorted_pending.size()));
        end
        if (sb.mismatch_count == 0) begin
            $display("merge_sort_engine_core verification clean");
        end else begin
            $display("merge_sort_engine_core verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/mse_pkg.sv
design/mse_ctrl.sv
design/mse_dp.sv
design/merge_sort_engine_core.sv
design/mse_checker.sv
bench/sort_check_pkg.sv
bench/testbench.sv
